// File: rtl/core/ansi_csi_sgr_color_parser_unit_macros.svh
// Assertion helpers shared by the parser RTL.
// Every check is disabled while rst_n is low and is sampled on clk.
`ifndef ANSI_CSI_SGR_COLOR_PARSER_UNIT_MACROS_SVH
`define ANSI_CSI_SGR_COLOR_PARSER_UNIT_MACROS_SVH

// Same-cycle implication.
`define ACSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ACSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/acsp_pkg.sv
`timescale 1ns / 1ps
package acsp_pkg;

  // Width of the saturating sequence length counter.
  localparam int LENGTH_BITS = 8;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

  // Byte codes.
  localparam logic [7:0] CH_ESC       = 8'h1b;
  localparam logic [7:0] CH_LBRACKET  = 8'h5b;
  localparam logic [7:0] CH_SEMICOLON = 8'h3b;
  localparam logic [7:0] CH_M         = 8'h6d;
  localparam logic [7:0] CH_DIGIT_MAX = 8'h39;
  localparam logic [7:0] PARAM_LO     = 8'h30;
  localparam logic [7:0] PARAM_HI     = 8'h3f;
  localparam logic [7:0] INTER_LO     = 8'h20;
  localparam logic [7:0] INTER_HI     = 8'h2f;
  localparam logic [7:0] FINAL_LO     = 8'h40;
  localparam logic [7:0] FINAL_HI     = 8'h7e;

  // SGR field values with special meaning.
  localparam logic [5:0] SGR_RESET    = 6'd0;
  localparam logic [5:0] SGR_DIM      = 6'd2;
  localparam logic [5:0] SGR_NORMAL   = 6'd22;
  localparam logic [5:0] SGR_FG_LO    = 6'd30;
  localparam logic [5:0] SGR_FG_RED   = 6'd31;
  localparam logic [5:0] SGR_FG_CYAN  = 6'd36;
  localparam logic [5:0] SGR_FG_HI    = 6'd37;
  localparam logic [5:0] SGR_EXT_FG   = 6'd38;
  localparam logic [5:0] SGR_DEF_FG   = 6'd39;
  localparam logic [5:0] SGR_EXT_BG   = 6'd48;
  localparam logic [5:0] SGR_EXT_UL   = 6'd58;
  localparam logic [5:0] FIELD_SAT    = 6'd63;

  // Colour word: bit 6 is the valid flag, bits 5:0 the code.
  localparam logic [6:0] COLOR_NONE   = 7'h00;
  localparam logic [6:0] COLOR_SEL0   = 7'h40;

  localparam logic [2:0] CLS_NONE     = 3'd0;
  localparam logic [2:0] CLS_GRAY     = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ESC   = 2'd1,
    PH_PARAM = 2'd2,
    PH_INTER = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    FM_EMPTY  = 2'd0,
    FM_DIGITS = 2'd1,
    FM_ENDED  = 2'd2,
    FM_BAD    = 2'd3
  } fmode_t;

  typedef struct packed {
    phase_t                 phase;
    logic [LENGTH_BITS-1:0] count;
    logic                   any_param;
    logic [5:0]             value;
    fmode_t                 mode;
    logic                   stopped;
    logic [6:0]             pending;
    logic [6:0]             last;
  } state_t;

  typedef struct packed {
    logic       seq_done;
    logic [7:0] final_byte;
    logic [7:0] seq_length;
    logic       color_valid;
    logic [5:0] color_code;
    logic [2:0] closed_span_class;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:     PH_IDLE,
    count:     '0,
    any_param: 1'b0,
    value:     '0,
    mode:      FM_EMPTY,
    stopped:   1'b0,
    pending:   COLOR_NONE,
    last:      COLOR_NONE
  };

endpackage

// File: rtl/core/ansi_csi_sgr_color_parser_unit.sv
`timescale 1ns / 1ps
// A byte accepted into the input stage moves on into the result register
// when that register is empty or being drained; its result beat is taken there.
// Throughput: one byte per clock; the input stage and the result register
// both advance whenever the result register is empty or being drained.
// Reset (rst_n low, synchronous): both stages empty, parser idle, no colour
// remembered. No clearing pass is needed; the block is ready at once.
`include "ansi_csi_sgr_color_parser_unit_macros.svh"
module ansi_csi_sgr_color_parser_unit import acsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_seq_done,
  output logic [7:0] out_final_byte,
  output logic [7:0] out_seq_length,
  output logic       out_color_valid,
  output logic [5:0] out_color_code,
  output logic [2:0] out_closed_span_class
);

  // Input stage: holds one byte beat until the parser core can consume it.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Result register and the parser's architectural state.
  logic       out_valid_r;
  result_t    out_res_r;
  state_t     st_r;

  state_t     st_nxt;
  result_t    res_nxt;
  logic       adv;

  // The core advances when the result register is free or is being taken
  // this cycle. The input stage refills in the same cycle it empties, so a
  // continuous stream of beats flows without bubbles.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;

  // The whole per-byte parse is a short combinational step: phase decode,
  // one multiply-by-ten on a six-bit field value, and the SGR classifier.
  acsp_step u_step (
    .i_byte (s1_byte_r),
    .i_st   (st_r),
    .o_st   (st_nxt),
    .o_res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      // State moves only when a byte really passes through the core.
      if (adv && s1_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers carry no reset; their valid flags qualify them.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
    end
    if (adv && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_seq_done          = out_res_r.seq_done;
  assign out_final_byte        = out_res_r.final_byte;
  assign out_seq_length        = out_res_r.seq_length;
  assign out_color_valid       = out_res_r.color_valid;
  assign out_color_code        = out_res_r.color_code;
  assign out_closed_span_class = out_res_r.closed_span_class;

  // A colour is only ever reported for a completed SGR sequence.
  `ACSP_ASSERT_NOW(a_color_needs_sgr, out_valid_r && out_res_r.color_valid,
    out_res_r.seq_done && out_res_r.final_byte == CH_M, "colour without SGR")

  // Without a completed sequence every other result field is zero.
  `ACSP_ASSERT_NOW(a_idle_result_zero, out_valid_r && !out_res_r.seq_done,
    out_res_r.final_byte == 8'h00 && out_res_r.seq_length == 8'h00 &&
    !out_res_r.color_valid && out_res_r.closed_span_class == CLS_NONE,
    "nonzero result without sequence")

  // A completed sequence holds at least ESC, bracket and final byte.
  `ACSP_ASSERT_NOW(a_min_length, out_valid_r && out_res_r.seq_done,
    out_res_r.seq_length >= 8'd3, "sequence too short")

  // Completing a sequence always returns the parser to idle.
  `ACSP_ASSERT_NEXT(a_done_goes_idle, adv && s1_valid_r && res_nxt.seq_done,
    st_r.phase == PH_IDLE, "parser not idle after final byte")

endmodule

// File: rtl/core/acsp_step.sv
`timescale 1ns / 1ps
// Parser state update and result for one byte.
module acsp_step import acsp_pkg::*; (
  input  logic [7:0] i_byte,
  input  state_t     i_st,
  output state_t     o_st,
  output result_t    o_res
);

  function automatic state_t clear_fields(input state_t s);
    state_t t;
    t = s;
    t.any_param = 1'b0;
    t.value     = '0;
    t.mode      = FM_EMPTY;
    t.stopped   = 1'b0;
    t.pending   = COLOR_NONE;
    return t;
  endfunction

  function automatic state_t close_field(input state_t s);
    state_t     t;
    logic [5:0] c;
    t = s;
    c = s.value;
    if (!s.stopped && (s.mode == FM_DIGITS || s.mode == FM_ENDED)) begin
      if (c == SGR_DEF_FG) begin
        t.pending = COLOR_SEL0;
      end else if (c == SGR_EXT_FG) begin
        t.pending = COLOR_SEL0;
        t.stopped = 1'b1;
      end else if (c == SGR_EXT_BG || c == SGR_EXT_UL) begin
        t.stopped = 1'b1;
      end else if (c == SGR_RESET || c == SGR_DIM || c == SGR_NORMAL ||
                   (c >= SGR_FG_LO && c <= SGR_FG_HI)) begin
        t.pending = {1'b1, c};
      end
    end
    t.value = '0;
    t.mode  = FM_EMPTY;
    return t;
  endfunction

  function automatic state_t param_byte(input state_t s, input logic [7:0] b);
    state_t     t;
    logic [9:0] v;
    t = s;
    t.any_param = 1'b1;
    v = ({4'b0, s.value} * 10'd10) + {6'b0, b[3:0]};
    if (b == CH_SEMICOLON) begin
      t = close_field(t);
    end else if (b <= CH_DIGIT_MAX) begin
      if (s.mode == FM_EMPTY || s.mode == FM_DIGITS) begin
        t.value = (v > {4'b0, FIELD_SAT}) ? FIELD_SAT : v[5:0];
        t.mode  = FM_DIGITS;
      end
    end else begin
      if (s.mode == FM_EMPTY) begin
        t.mode = FM_BAD;
      end else if (s.mode == FM_DIGITS) begin
        t.mode = FM_ENDED;
      end
    end
    return t;
  endfunction

  function automatic logic [2:0] span_class(input logic [6:0] lc);
    logic [5:0] d;
    d = lc[5:0] - SGR_FG_LO;
    if (!lc[6]) begin
      return CLS_NONE;
    end else if (lc[5:0] >= SGR_FG_RED && lc[5:0] <= SGR_FG_CYAN) begin
      return d[2:0];
    end else if (lc[5:0] == SGR_FG_HI || lc[5:0] == SGR_DIM) begin
      return CLS_GRAY;
    end
    return CLS_NONE;
  endfunction

  function automatic logic [7:0] sat_len(input logic [LENGTH_BITS-1:0] n);
    logic [LENGTH_BITS+7:0] e;
    e = {8'b0, n};
    return (e > (LENGTH_BITS+8)'(255)) ? 8'hff : e[7:0];
  endfunction

  logic       is_param;
  logic       is_inter;
  logic       is_final;
  logic [6:0] col;

  assign is_param = (i_byte >= PARAM_LO) && (i_byte <= PARAM_HI);
  assign is_inter = (i_byte >= INTER_LO) && (i_byte <= INTER_HI);
  assign is_final = (i_byte >= FINAL_LO) && (i_byte <= FINAL_HI);

  always_comb begin
    o_st  = i_st;
    o_res = '0;
    col   = COLOR_NONE;
    if (i_byte == CH_ESC) begin
      o_st       = clear_fields(i_st);
      o_st.phase = PH_ESC;
      o_st.count = LEN_ONE;
    end else if (i_st.phase != PH_IDLE) begin
      if (i_st.count != LEN_MAX) begin
        o_st.count = i_st.count + LEN_ONE;
      end
      priority if (i_byte == CH_LBRACKET) begin
        o_st.phase = (i_st.phase == PH_ESC) ? PH_PARAM : PH_IDLE;
      end else if (is_param) begin
        if (i_st.phase == PH_PARAM) begin
          o_st = param_byte(o_st, i_byte);
        end else begin
          o_st.phase = PH_IDLE;
        end
      end else if (is_inter) begin
        if (i_st.phase == PH_PARAM) begin
          o_st.phase = PH_INTER;
        end else if (i_st.phase != PH_INTER) begin
          o_st.phase = PH_IDLE;
        end
      end else if (is_final) begin
        if (i_st.phase == PH_PARAM || i_st.phase == PH_INTER) begin
          o_res.seq_done   = 1'b1;
          o_res.final_byte = i_byte;
          o_res.seq_length = sat_len(o_st.count);
          if (i_byte == CH_M) begin
            // A bare SGR with no parameters means a full reset.
            if (!i_st.any_param) begin
              col = COLOR_SEL0;
            end else begin
              o_st = close_field(o_st);
              col  = o_st.pending;
            end
            o_res.closed_span_class = span_class(i_st.last);
            if (col[6]) begin
              o_res.color_valid = 1'b1;
              o_res.color_code  = col[5:0];
              o_st.last         = col;
            end
          end
        end
        o_st.phase = PH_IDLE;
      end else begin
        o_st.phase = PH_IDLE;
      end
    end
  end

endmodule

// File: verif/ansi_csi_sgr_color_parser_checker.sv
`timescale 1ns / 1ps
module ansi_csi_sgr_color_parser_checker import acsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_seq_done,
  input  logic [7:0] out_final_byte,
  input  logic [7:0] out_seq_length,
  input  logic       out_color_valid,
  input  logic [5:0] out_color_code,
  input  logic [2:0] out_closed_span_class,
  output int         mismatch_count,
  output int         results_owed
);

  result_t                owed_q[$];
  phase_t                 phase;
  logic [LENGTH_BITS-1:0] seq_count;
  logic                   seen_param;
  logic [5:0]             field_val;
  fmode_t                 field_st;
  logic                   field_stop;
  logic [6:0]             pend_color;
  logic [6:0]             shown_color;

  initial begin
    mismatch_count = 0;
    results_owed = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic void clear_sgr_fields();
    seen_param = 1'b0;
    field_val = '0;
    field_st = FM_EMPTY;
    field_stop = 1'b0;
    pend_color = COLOR_NONE;
  endfunction

  // A field counts only if it began with a digit and no stop code came before it.
  function automatic void close_sgr_field();
    if (!field_stop && (field_st == FM_DIGITS || field_st == FM_ENDED)) begin
      if (field_val == SGR_DEF_FG) begin
        pend_color = COLOR_SEL0;
      end else if (field_val == SGR_EXT_FG) begin
        pend_color = COLOR_SEL0;
        field_stop = 1'b1;
      end else if (field_val == SGR_EXT_BG || field_val == SGR_EXT_UL) begin
        field_stop = 1'b1;
      end else if (field_val == SGR_RESET || field_val == SGR_DIM || field_val == SGR_NORMAL ||
                   (field_val >= SGR_FG_LO && field_val <= SGR_FG_HI)) begin
        pend_color = {1'b1, field_val};
      end
    end
    field_val = '0;
    field_st = FM_EMPTY;
  endfunction

  function automatic void take_param_byte(input logic [7:0] b);
    int acc;
    seen_param = 1'b1;
    if (b == CH_SEMICOLON) begin
      close_sgr_field();
    end else if (b <= CH_DIGIT_MAX) begin
      if (field_st == FM_EMPTY || field_st == FM_DIGITS) begin
        acc = int'(field_val) * 10 + int'(b - PARAM_LO);
        field_val = (acc > int'(FIELD_SAT)) ? FIELD_SAT : acc[5:0];
        field_st = FM_DIGITS;
      end
    end else begin
      if (field_st == FM_EMPTY) field_st = FM_BAD;
      else if (field_st == FM_DIGITS) field_st = FM_ENDED;
    end
  endfunction

  function automatic logic [2:0] span_class_of(input logic [6:0] c);
    if (!c[6]) return CLS_NONE;
    if (c[5:0] >= SGR_FG_RED && c[5:0] <= SGR_FG_CYAN) return 3'(c[5:0] - SGR_FG_LO);
    if (c[5:0] == SGR_FG_HI || c[5:0] == SGR_DIM) return CLS_GRAY;
    return CLS_NONE;
  endfunction

  function automatic result_t predict_byte(input logic [7:0] b);
    result_t    r;
    logic [6:0] col;
    r = '0;
    if (b == CH_ESC) begin
      phase = PH_ESC;
      seq_count = LEN_ONE;
      clear_sgr_fields();
    end else if (phase != PH_IDLE) begin
      if (seq_count != LEN_MAX) seq_count = seq_count + 1'b1;
      if (b == CH_LBRACKET) begin
        phase = (phase == PH_ESC) ? PH_PARAM : PH_IDLE;
      end else if (b >= PARAM_LO && b <= PARAM_HI) begin
        if (phase == PH_PARAM) take_param_byte(b);
        else phase = PH_IDLE;
      end else if (b >= INTER_LO && b <= INTER_HI) begin
        if (phase == PH_PARAM) phase = PH_INTER;
        else if (phase != PH_INTER) phase = PH_IDLE;
      end else if (b >= FINAL_LO && b <= FINAL_HI) begin
        if (phase == PH_PARAM || phase == PH_INTER) begin
          r.seq_done = 1'b1;
          r.final_byte = b;
          r.seq_length = (int'(seq_count) > 255) ? 8'hff : 8'(seq_count);
          if (b == CH_M) begin
            if (!seen_param) begin
              col = COLOR_SEL0;
            end else begin
              close_sgr_field();
              col = pend_color;
            end
            r.closed_span_class = span_class_of(shown_color);
            if (col[6]) begin
              r.color_valid = 1'b1;
              r.color_code = col[5:0];
              shown_color = col;
            end
          end
        end
        phase = PH_IDLE;
      end else begin
        phase = PH_IDLE;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      phase = PH_IDLE;
      seq_count = '0;
      clear_sgr_fields();
      shown_color = COLOR_NONE;
      owed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("result beat arrived with no byte waiting for it");
        end else begin
          want = owed_q.pop_front();
          check_field("seq_done", out_seq_done, want.seq_done);
          check_field("final_byte", out_final_byte, want.final_byte);
          check_field("seq_length", out_seq_length, want.seq_length);
          check_field("color_valid", out_color_valid, want.color_valid);
          check_field("color_code", out_color_code, want.color_code);
          check_field("closed_span_class", out_closed_span_class, want.closed_span_class);
        end
      end
      if (in_valid && in_ready) owed_q.push_back(predict_byte(in_byte));
    end
    results_owed <= owed_q.size();
  end

endmodule

// File: verif/ansi_csi_sgr_color_parser_unit_test.sv
`timescale 1ns / 1ps
module ansi_csi_sgr_color_parser_unit_test;
  import acsp_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_seq_done;
  logic [7:0] out_final_byte;
  logic [7:0] out_seq_length;
  logic       out_color_valid;
  logic [5:0] out_color_code;
  logic [2:0] out_closed_span_class;
  int         mismatch_count;
  int         results_owed;

  // Bytes of the sequence being built, flushed to the block by emit_bytes.
  logic [7:0] seq_q[$];
  int         sent_bytes = 0;

  // Each side alternates between stretches of random gaps and stretches of
  // back-to-back beats; the receiver also honors a one-shot long hold-off.
  bit         snd_calm = 1'b0;
  bit         rcv_calm = 1'b0;
  bit         hold_off_req = 1'b0;

  ansi_csi_sgr_color_parser_unit uut (.*);

  ansi_csi_sgr_color_parser_checker sgr_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one byte and return at the edge where it is accepted. When the
  // drawn gap is zero, valid simply stays high and only the payload moves,
  // so valid never gets two assignments in one time step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) snd_calm = !snd_calm;
    gap = snd_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic emit_bytes();
    foreach (seq_q[i]) send_byte(seq_q[i]);
    sent_bytes += seq_q.size();
    seq_q.delete();
  endtask

  task automatic begin_csi();
    seq_q.push_back(CH_ESC);
    seq_q.push_back(CH_LBRACKET);
  endtask

  // Decimal text of a value, as the terminal would send it.
  task automatic add_number(input int v);
    string digits;
    digits = $sformatf("%0d", v);
    for (int i = 0; i < digits.len(); i++) seq_q.push_back(digits[i]);
  endtask

  // A parameter byte that is neither a digit nor the field separator.
  function automatic logic [7:0] param_junk();
    logic [7:0] b;
    b = 8'($urandom_range(CH_SEMICOLON + 1, PARAM_HI));
    if ($urandom_range(0, 2) == 0) b = CH_DIGIT_MAX + 1'b1;
    return b;
  endfunction

  // Only codes that select a colour, so spans of every class get closed.
  function automatic int pick_color_code();
    case ($urandom_range(0, 5))
      0: return SGR_RESET;
      1: return SGR_DIM;
      2: return SGR_NORMAL;
      3: return SGR_DEF_FG;
      default: return $urandom_range(SGR_FG_LO, SGR_FG_HI);
    endcase
  endfunction

  // One SGR field: empty, bad start, digits cut short by a non-digit,
  // saturating values, the stop codes, leading zeros, or a plain code.
  task automatic add_sgr_field();
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        seq_q.push_back(param_junk());
        if ($urandom_range(0, 1) == 1) add_number(pick_color_code());
      end
      2: begin
        add_number(pick_color_code());
        seq_q.push_back(param_junk());
        add_number($urandom_range(0, 9));
      end
      3: add_number($urandom_range(0, 999));
      4: begin
        case ($urandom_range(0, 2))
          0: add_number(SGR_EXT_FG);
          1: add_number(SGR_EXT_BG);
          default: add_number(SGR_EXT_UL);
        endcase
      end
      5: begin
        seq_q.push_back(PARAM_LO);
        add_number(pick_color_code());
      end
      default: add_number(pick_color_code());
    endcase
  endtask

  // The receiver draws its own wait before every result beat. Once asked,
  // it holds ready low for a long count of cycles so the two internal stages
  // fill and the block must push back on the sender.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if ($urandom_range(0, 39) == 0) rcv_calm = !rcv_calm;
      gap = rcv_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int pick;
    int nfields;
    int long_sent;
    bit hold_done;
    bit drain_done;
    long_sent = 0;
    hold_done = 1'b0;
    drain_done = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. An SGR sequence with no parameter bytes selects the
    // reset code.
    begin_csi();
    seq_q.push_back(CH_M);
    // A bad-start field, a saturating value, then 31 whose digits are ended
    // by a non-digit parameter byte.
    begin_csi();
    seq_q.push_back(PARAM_HI - 3'd3);
    seq_q.push_back(CH_SEMICOLON);
    add_number(99);
    seq_q.push_back(CH_SEMICOLON);
    add_number(31);
    seq_q.push_back(PARAM_HI);
    seq_q.push_back(CH_M);
    // 38 selects the reset code and ignores everything after it; this also
    // closes the red span.
    begin_csi();
    add_number(38);
    seq_q.push_back(CH_SEMICOLON);
    add_number(32);
    seq_q.push_back(CH_M);
    // A final byte right after ESC drops the sequence without a report.
    seq_q.push_back(CH_ESC);
    seq_q.push_back(CH_M);
    // A bracket anywhere but right after ESC drops the sequence.
    begin_csi();
    seq_q.push_back(CH_LBRACKET);
    // Intermediate byte, then the highest final byte.
    begin_csi();
    add_number(2);
    seq_q.push_back(INTER_HI);
    seq_q.push_back(FINAL_HI);
    emit_bytes();

    // Random part: mostly well-formed sequences with random fields, some
    // broken sequences and some raw noise.
    while (sent_bytes < 1400) begin
      // Long receiver stall while the sender keeps offering bytes.
      if (!hold_done && sent_bytes >= 400) begin
        hold_done = 1'b1;
        hold_off_req = 1'b1;
      end
      // Sender goes quiet until every result has been drained.
      if (!drain_done && sent_bytes >= 800) begin
        drain_done = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
      end
      // A couple of sequences long enough to saturate the length counter.
      if (long_sent < 2 && sent_bytes >= 300 + 600 * long_sent) begin
        long_sent++;
        begin_csi();
        repeat (260 + $urandom_range(0, 20))
          seq_q.push_back(8'($urandom_range(PARAM_LO, CH_SEMICOLON)));
        seq_q.push_back(CH_M);
        emit_bytes();
      end

      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        begin_csi();
        nfields = $urandom_range(0, 4);
        for (int i = 0; i < nfields; i++) begin
          if (i > 0) seq_q.push_back(CH_SEMICOLON);
          add_sgr_field();
        end
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 2)) seq_q.push_back(8'($urandom_range(INTER_LO, INTER_HI)));
        seq_q.push_back(($urandom_range(0, 4) != 0) ? CH_M
                                                    : 8'($urandom_range(FINAL_LO, FINAL_HI)));
      end else if (pick < 85) begin
        // Broken sequence: the parser must abort or restart cleanly.
        begin_csi();
        add_number($urandom_range(0, 99));
        case ($urandom_range(0, 4))
          0: seq_q.push_back(CH_LBRACKET);
          1: begin
            seq_q.push_back(CH_ESC);
            seq_q.push_back(CH_M);
          end
          2: seq_q.push_back(8'($urandom_range(0, INTER_LO - 1)));
          3: seq_q.push_back(8'($urandom_range(FINAL_HI + 1, 255)));
          default: begin
            seq_q.push_back(INTER_LO);
            seq_q.push_back(PARAM_LO);
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 6)) seq_q.push_back(8'($urandom_range(0, 255)));
      end
      emit_bytes();
    end

    // Drain: wait for every owed result, then a few cycles more so a stray
    // extra beat would still be caught by the checker.
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: ansi_csi_sgr_color_parser_unit.f
+incdir+rtl/core
rtl/core/acsp_pkg.sv
rtl/core/acsp_step.sv
rtl/core/ansi_csi_sgr_color_parser_unit.sv
verif/ansi_csi_sgr_color_parser_checker.sv
verif/ansi_csi_sgr_color_parser_unit_test.sv
